// ----- design/pbf_pkg.sv -----
// Package for the polynomial bond force unit: payload structs, state codes,
// table geometry and saturation helpers. No dependencies.
package pbf_pkg;

   // Table geometry
   localparam int NUM_TYPES   = 64;
   localparam int POLY_DEGREE = 6;
   localparam int SLOTS       = 15;
   localparam int SLOT_DC     = 7;
   localparam int SLOT_EQ     = 13;
   localparam int SLOT_EQR    = 14;
   localparam int TYPE_IDX_W  = $clog2(NUM_TYPES);
   localparam int ADDR_W      = $clog2(NUM_TYPES * SLOTS);
   localparam int MEM_DEPTH   = NUM_TYPES * SLOTS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Operation codes
   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_FORCE_WEIGHT  = 2'd0;
   localparam logic [1:0] CSR_PRESSURE_MODE = 2'd1;
   localparam logic [1:0] CSR_EQ_SELECT     = 2'd2;

   // Pressure modes
   localparam logic [1:0] PMODE_NONE = 2'd0;
   localparam logic [1:0] PMODE_DIAG = 2'd1;

   typedef struct packed {
      logic               op;
      logic [5:0]         bond_type;
      logic [3:0]         coef_slot;
      logic signed [31:0] coef_value;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [31:0] disp_z;
      logic               last_bond;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] bond_energy;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [47:0] energy_total;
      logic signed [47:0] press_xx;
      logic signed [47:0] press_yy;
      logic signed [47:0] press_zz;
      logic signed [47:0] press_xy;
      logic signed [47:0] press_xz;
      logic signed [47:0] press_yz;
      logic               totals_valid;
   } rsp_item_type;

   // Classified command handed from the front to the engine
   typedef struct packed {
      logic               is_write;
      logic               last;
      logic [ADDR_W-1:0]  base;
      logic [3:0]         slot;
      logic signed [31:0] value;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } cmd_type;

   // Queue handshake between front and engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_RD_EQ, ST_RR0, ST_LOAD,
      ST_H_MUL, ST_H_ADD, ST_RD_D, ST_DIV_SET, ST_DIV, ST_PRE,
      ST_F_MUL, ST_F_ADD, ST_W_MUL, ST_W_ADD, ST_T_MUL, ST_T_ADD, ST_FIN
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -49'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v[48] != v[47]) r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else                r = v[47:0];
      return r;
   endfunction

   // Tensor term t uses d[term_d(t)] * f[term_f(t)]: xx yy zz xy xz yz
   function automatic logic [1:0] term_d(input logic [2:0] t);
      logic [1:0] r;
      case (t)
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd2;
         3'd5:    r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] term_f(input logic [2:0] t);
      logic [1:0] r;
      case (t)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd1;
         3'd3:    r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

// ----- design/pbf_front.sv -----
// Front end: accepts request transactions, classifies them into commands
// (table row base address) and buffers them in a short queue. Uses pbf_pkg.
module pbf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  pbf_pkg::req_item_type req_item,
   output pbf_pkg::queue_head_type q_head,
   input  logic                  q_pop
);
   import pbf_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W:0]      count_ff;
   cmd_type              cmd_new;
   logic [TYPE_IDX_W-1:0] type_idx;
   logic                 do_push;
   logic                 do_pop;

   // Classify: row base = type * 15
   always_comb begin
      type_idx         = req_item.bond_type[TYPE_IDX_W-1:0];
      cmd_new.is_write = (req_item.op == OP_WRITE);
      cmd_new.last     = req_item.last_bond;
      cmd_new.base     = ADDR_W'({type_idx, 4'b0000}) - ADDR_W'(type_idx);
      cmd_new.slot     = req_item.coef_slot;
      cmd_new.value    = req_item.coef_value;
      cmd_new.dx       = req_item.disp_x;
      cmd_new.dy       = req_item.disp_y;
      cmd_new.dz       = req_item.disp_z;
   end

   assign req_full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push      = req_push && !req_full;
   assign do_pop       = q_pop && (count_ff != '0);
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (!do_push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- design/pbf_engine.sv -----
// Back end: coefficient table, sequencer with one shared 32x32 multiplier,
// radix-2 square root and divider, accumulators and result register. Uses pbf_pkg.
module pbf_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  pbf_pkg::queue_head_type q_head,
   output logic                    q_pop,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output pbf_pkg::rsp_item_type   rsp_item
);
   import pbf_pkg::*;

   state_type state_ff, state_in;

   // Configuration
   logic signed [31:0] fw_ff;
   logic [1:0]         mode_ff;
   logic               eqsel_ff;

   // Coefficient table
   logic signed [31:0] coef_mem [MEM_DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [3:0]         rd_slot;
   logic               mem_we;

   // Datapath
   cmd_type            cmd_ff;
   logic [2:0]         k_ff;
   logic [5:0]         cnt_ff;
   logic [63:0]        r2_ff;
   logic [63:0]        rad_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        root_ff;
   logic signed [31:0] rr0_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] energy_ff;
   logic               phase_ff;
   logic [47:0]        num_ff;
   logic [31:0]        drem_ff;
   logic               neg_ff;
   logic signed [31:0] pre_ff;
   logic signed [31:0] f_ff  [3];
   logic signed [31:0] wf_ff [3];
   logic signed [47:0] tens_ff [6];
   logic signed [47:0] ea_ff;
   logic signed [63:0] prod_ff;
   rsp_item_type       rsp_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [47:0] prod_sh;
   logic signed [31:0] horner_new;
   logic [35:0]        sq_rem_t;
   logic [33:0]        sq_trial;
   logic [32:0]        dv_rem_t;
   logic               dv_ge;
   logic signed [47:0] ea_new;
   logic [63:0]        r2_sum;
   logic               out_free;
   logic               term_sel;

   function automatic logic signed [31:0] disp(input cmd_type c, input logic [1:0] i);
      logic signed [31:0] r;
      case (i)
         2'd0:    r = c.dx;
         2'd1:    r = c.dy;
         default: r = c.dz;
      endcase
      return r;
   endfunction

   assign prod_sh    = $signed(prod_ff[63:16]);
   assign horner_new = sat32(49'(prod_sh) + 49'(rd_data_ff));
   assign r2_sum     = r2_ff + prod_ff;
   assign sq_rem_t   = {rem_ff, rad_ff[63:62]};
   assign sq_trial   = {root_ff, 2'b01};
   assign dv_rem_t   = {drem_ff, num_ff[47]};
   assign dv_ge      = (dv_rem_t >= {1'b0, root_ff});
   assign ea_new     = sat48(49'(ea_ff) + 49'(energy_ff));
   assign out_free   = !rsp_valid_ff || rsp_pop;
   assign term_sel   = (mode_ff != PMODE_NONE) && ((k_ff < 3'd4) || (mode_ff != PMODE_DIAG));
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= 32'sd65536;
         mode_ff  <= PMODE_NONE;
         eqsel_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORCE_WEIGHT:  fw_ff    <= csr_wdata;
            CSR_PRESSURE_MODE: mode_ff  <= csr_wdata[1:0];
            CSR_EQ_SELECT:     eqsel_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Next state, queue pop, table port and multiplier operands
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      rd_slot  = 4'd0;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.cmd.is_write) mem_we = (q_head.cmd.slot != 4'd15);
               else                     state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = disp(cmd_ff, k_ff[1:0]);
            mul_b    = disp(cmd_ff, k_ff[1:0]);
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: state_in = (k_ff == 3'd2) ? ST_SQRT : ST_SQ_MUL;
         ST_SQRT:   if (cnt_ff == 6'd31) state_in = ST_RD_EQ;
         ST_RD_EQ: begin
            rd_slot  = eqsel_ff ? 4'(SLOT_EQR) : 4'(SLOT_EQ);
            state_in = ST_RR0;
         end
         ST_RR0: begin
            rd_slot  = 4'(POLY_DEGREE);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!phase_ff || POLY_DEGREE >= 2) state_in = ST_H_MUL;
            else                               state_in = ST_DIV_SET;
         end
         ST_H_MUL: begin
            rd_slot  = (phase_ff ? 4'(SLOT_DC) : 4'd0) + 4'(k_ff);
            mul_a    = acc_ff;
            mul_b    = rr0_ff;
            state_in = ST_H_ADD;
         end
         ST_H_ADD: begin
            if (k_ff != 3'd0)  state_in = ST_H_MUL;
            else if (phase_ff) state_in = ST_DIV_SET;
            else               state_in = ST_RD_D;
         end
         ST_RD_D: begin
            rd_slot  = 4'(SLOT_DC + POLY_DEGREE - 1);
            state_in = ST_LOAD;
         end
         ST_DIV_SET: state_in = (root_ff == '0) ? ST_F_MUL : ST_DIV;
         ST_DIV:     if (cnt_ff == 6'd47) state_in = ST_PRE;
         ST_PRE:     state_in = ST_F_MUL;
         ST_F_MUL: begin
            mul_a    = disp(cmd_ff, k_ff[1:0]);
            mul_b    = pre_ff;
            state_in = ST_F_ADD;
         end
         ST_F_ADD: state_in = (k_ff == 3'd2) ? ST_W_MUL : ST_F_MUL;
         ST_W_MUL: begin
            mul_a    = f_ff[k_ff[1:0]];
            mul_b    = fw_ff;
            state_in = ST_W_ADD;
         end
         ST_W_ADD: state_in = (k_ff == 3'd2) ? ST_T_MUL : ST_W_MUL;
         ST_T_MUL: begin
            mul_a    = disp(cmd_ff, term_d(k_ff));
            mul_b    = f_ff[term_f(k_ff)];
            state_in = ST_T_ADD;
         end
         ST_T_ADD: state_in = (k_ff == 3'd5) ? ST_FIN : ST_T_MUL;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Coefficient table: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[q_head.cmd.base + ADDR_W'(q_head.cmd.slot)] <= q_head.cmd.value;
      end
      rd_data_ff <= coef_mem[cmd_ff.base + ADDR_W'(rd_slot)];
   end

   // Shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) cmd_ff <= q_head.cmd;
            k_ff  <= '0;
            r2_ff <= '0;
         end
         ST_SQ_ACC: begin
            r2_ff   <= r2_sum;
            rad_ff  <= r2_sum;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            k_ff    <= k_ff + 3'd1;
         end
         // One result bit per cycle
         ST_SQRT: begin
            if (sq_rem_t >= 36'(sq_trial)) begin
               rem_ff  <= 34'(sq_rem_t - 36'(sq_trial));
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= sq_rem_t[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            rad_ff <= {rad_ff[61:0], 2'b00};
            cnt_ff <= cnt_ff + 6'd1;
         end
         ST_RR0: begin
            rr0_ff   <= sat32(49'($signed({1'b0, root_ff})) - 49'(rd_data_ff));
            k_ff     <= 3'(POLY_DEGREE - 1);
            phase_ff <= 1'b0;
         end
         ST_LOAD:  acc_ff <= rd_data_ff;
         ST_H_ADD: begin
            acc_ff <= horner_new;
            if (k_ff != 3'd0) begin
               k_ff <= k_ff - 3'd1;
            end else if (!phase_ff) begin
               energy_ff <= horner_new;
               phase_ff  <= 1'b1;
               k_ff      <= (POLY_DEGREE >= 2) ? 3'(POLY_DEGREE - 2) : 3'd0;
            end
         end
         ST_DIV_SET: begin
            num_ff  <= {(acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff)), 16'd0};
            neg_ff  <= (acc_ff > 32'sd0);
            drem_ff <= '0;
            cnt_ff  <= '0;
            pre_ff  <= '0;
            k_ff    <= '0;
         end
         // Restoring divide, one quotient bit per cycle
         ST_DIV: begin
            drem_ff <= dv_ge ? 32'(dv_rem_t - {1'b0, root_ff}) : dv_rem_t[31:0];
            num_ff  <= {num_ff[46:0], dv_ge};
            cnt_ff  <= cnt_ff + 6'd1;
         end
         ST_PRE: pre_ff <= neg_ff ? sat32(-49'(num_ff)) : sat32(49'(num_ff));
         ST_F_ADD: begin
            f_ff[k_ff[1:0]] <= sat32(49'(prod_sh));
            k_ff <= (k_ff == 3'd2) ? 3'd0 : k_ff + 3'd1;
         end
         ST_W_ADD: begin
            wf_ff[k_ff[1:0]] <= sat32(49'(prod_sh));
            k_ff <= (k_ff == 3'd2) ? 3'd0 : k_ff + 3'd1;
         end
         ST_T_ADD: begin
            k_ff <= k_ff + 3'd1;
         end
         default: ;
      endcase
   end

   // Accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ea_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) tens_ff[i] <= '0;
      end else begin
         if (state_ff == ST_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_pop)                  rsp_valid_ff <= 1'b0;
         if (state_ff == ST_T_ADD && term_sel) begin
            tens_ff[k_ff] <= sat48(49'(tens_ff[k_ff]) + 49'(prod_sh));
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_ff.bond_energy   <= energy_ff;
            rsp_ff.force_x       <= wf_ff[0];
            rsp_ff.force_y       <= wf_ff[1];
            rsp_ff.force_z       <= wf_ff[2];
            rsp_ff.totals_valid  <= cmd_ff.last;
            rsp_ff.energy_total  <= cmd_ff.last ? ea_new : '0;
            rsp_ff.press_xx      <= cmd_ff.last ? tens_ff[0] : '0;
            rsp_ff.press_yy      <= cmd_ff.last ? tens_ff[1] : '0;
            rsp_ff.press_zz      <= cmd_ff.last ? tens_ff[2] : '0;
            rsp_ff.press_xy      <= cmd_ff.last ? tens_ff[3] : '0;
            rsp_ff.press_xz      <= cmd_ff.last ? tens_ff[4] : '0;
            rsp_ff.press_yz      <= cmd_ff.last ? tens_ff[5] : '0;
            if (cmd_ff.last) begin
               ea_ff <= '0;
               for (int i = 0; i < 6; i++) tens_ff[i] <= '0;
            end else begin
               ea_ff <= ea_new;
            end
         end
      end
   end

endmodule

// ----- design/polynomial_bond_force.sv -----
// Top level of the polynomial bond force unit: front queue plus engine.
// Depends on pbf_pkg, pbf_front and pbf_engine.
//
// The engine is a sequencer around one shared 32x32 multiplier. A bond's run from
// leaving the input queue to its result is mostly spent in the 32-step square
// root, the 48-step divider (skipped for a zero length) and the Horner steps.
// A coefficient write gives no result. A two-entry queue takes requests while
// a bond is at work, and a one-entry result register lets the next bond start
// while a finished result waits to be popped. The coefficient table is not
// cleared by reset: every entry a bond uses must be written first.
module polynomial_bond_force (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  pbf_pkg::req_item_type req_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output pbf_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import pbf_pkg::*;

   queue_head_type q_head;
   logic           q_pop;

   pbf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   pbf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTH
   // Engine never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("engine popped empty queue");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");

   // Batch totals are zero unless flagged
   a_totals_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.totals_valid) |-> (rsp_item.energy_total == '0))
      else $error("totals reported on non-last bond");
`endif

endmodule

// ----- dv/tb.sv -----
// Testbench for polynomial_bond_force: random and directed bond transactions,
// checked against a bit-accurate predictor. Depends on pbf_pkg and the RTL.
`timescale 1ns/1ps

import pbf_pkg::*;

// Tracks coefficient table, registers and batch sums, and holds the
// responses that accepted bonds will produce.
class bond_scoreboard;
   int           coef[MEM_DEPTH];
   longint       energy_sum;
   longint       virial_sum[6];
   int           weight;
   bit [1:0]     pmode;
   bit           eq_res;
   rsp_item_type pending[$];
   int           errors;

   function new();
      energy_sum = 0;
      foreach (virial_sum[i]) virial_sum[i] = 0;
      weight = 65536;
      pmode  = PMODE_NONE;
      eq_res = 0;
      errors = 0;
   endfunction

   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint clip48(longint v);
      if (v > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
      if (v < -64'sh800000000000) return -64'sh800000000000;
      return v;
   endfunction

   function longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
         CSR_FORCE_WEIGHT:  weight = $signed(val);
         CSR_PRESSURE_MODE: pmode  = val[1:0];
         CSR_EQ_SELECT:     eq_res = val[0];
         default: ;
      endcase
   endfunction

   // Accepted request: update the table or predict one bond response
   function void note_request(req_item_type it);
      int           base;
      longint       d[3];
      longint       f[3];
      longint       t[6];
      longint       r, rr0, acc, pre, energy;
      longint unsigned r2;
      rsp_item_type exp;
      base = int'(it.bond_type) * SLOTS;
      if (it.op == OP_WRITE) begin
         if (it.coef_slot < SLOTS) coef[base + it.coef_slot] = it.coef_value;
         return;
      end
      d[0] = it.disp_x;
      d[1] = it.disp_y;
      d[2] = it.disp_z;
      r2 = 0;
      for (int k = 0; k < 3; k++) r2 = r2 + longint'(d[k] * d[k]);
      r = longint'(root64(r2));
      rr0 = clip32(r - longint'(coef[base + (eq_res ? SLOT_EQR : SLOT_EQ)]));
      // Horner: energy polynomial, then derivative
      acc = coef[base + POLY_DEGREE];
      for (int k = POLY_DEGREE - 1; k >= 0; k--)
         acc = clip32(((acc * rr0) >>> 16) + longint'(coef[base + k]));
      energy = acc;
      acc = coef[base + SLOT_DC + POLY_DEGREE - 1];
      for (int k = POLY_DEGREE - 2; k >= 0; k--)
         acc = clip32(((acc * rr0) >>> 16) + longint'(coef[base + SLOT_DC + k]));
      pre = (r == 0) ? 0 : clip32((-acc * 65536) / r);
      exp = '0;
      exp.bond_energy = energy[31:0];
      for (int k = 0; k < 3; k++) f[k] = clip32((d[k] * pre) >>> 16);
      exp.force_x = 32'(clip32((f[0] * longint'(weight)) >>> 16));
      exp.force_y = 32'(clip32((f[1] * longint'(weight)) >>> 16));
      exp.force_z = 32'(clip32((f[2] * longint'(weight)) >>> 16));
      energy_sum = clip48(energy_sum + energy);
      if (pmode != PMODE_NONE) begin
         t[0] = (d[0] * f[0]) >>> 16;
         t[1] = (d[1] * f[1]) >>> 16;
         t[2] = (d[2] * f[2]) >>> 16;
         t[3] = (d[0] * f[1]) >>> 16;
         t[4] = (d[0] * f[2]) >>> 16;
         t[5] = (d[1] * f[2]) >>> 16;
         for (int k = 0; k < 4; k++) virial_sum[k] = clip48(virial_sum[k] + t[k]);
         if (pmode >= 2)
            for (int k = 4; k < 6; k++) virial_sum[k] = clip48(virial_sum[k] + t[k]);
      end
      if (it.last_bond) begin
         exp.energy_total = energy_sum[47:0];
         exp.press_xx     = virial_sum[0][47:0];
         exp.press_yy     = virial_sum[1][47:0];
         exp.press_zz     = virial_sum[2][47:0];
         exp.press_xy     = virial_sum[3][47:0];
         exp.press_xz     = virial_sum[4][47:0];
         exp.press_yz     = virial_sum[5][47:0];
         exp.totals_valid = 1'b1;
         energy_sum = 0;
         foreach (virial_sum[i]) virial_sum[i] = 0;
      end
      pending.push_back(exp);
   endfunction

   function void cmp(string name, logic [47:0] e, logic [47:0] a);
      if (e !== a) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
         errors++;
      end
   endfunction

   // Accepted response: compare with the oldest prediction
   function void check_response(rsp_item_type got);
      rsp_item_type exp;
      if (pending.size() == 0) begin
         $display("%0t unexpected response, energy %h", $time, got.bond_energy);
         errors++;
         return;
      end
      exp = pending.pop_front();
      cmp("bond_energy", 48'(exp.bond_energy), 48'(got.bond_energy));
      cmp("force_x", 48'(exp.force_x), 48'(got.force_x));
      cmp("force_y", 48'(exp.force_y), 48'(got.force_y));
      cmp("force_z", 48'(exp.force_z), 48'(got.force_z));
      cmp("energy_total", exp.energy_total, got.energy_total);
      cmp("press_xx", exp.press_xx, got.press_xx);
      cmp("press_yy", exp.press_yy, got.press_yy);
      cmp("press_zz", exp.press_zz, got.press_zz);
      cmp("press_xy", exp.press_xy, got.press_xy);
      cmp("press_xz", exp.press_xz, got.press_xz);
      cmp("press_yz", exp.press_yz, got.press_yz);
      cmp("totals_valid", 48'(exp.totals_valid), 48'(got.totals_valid));
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam int     DRAIN_CYCLES = 200;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   req_item_type req_item;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   bond_scoreboard sb = new();
   int           send_idle_pct;
   int           pop_stall_pct;
   int           hold_off;
   longint       cycles;
   bit [14:0]    written[NUM_TYPES];
   int           ready_types[$];

   polynomial_bond_force u_top (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: check at each pop, then choose the next pop value
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_response(rsp_item);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   task automatic send(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      sb.note_request(it);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_push  <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom_range(32'h3FFFF);
         1: return -$urandom_range(32'h3FFFF);
         2: return $urandom_range(32'h3FFFFF) - 32'h1FFFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type coef_write(int ty, int slot, logic [31:0] val);
      req_item_type it;
      it = '0;
      it.op = OP_WRITE;
      it.bond_type = 6'(ty);
      it.coef_slot = 4'(slot);
      it.coef_value = val;
      it.disp_x = $urandom;
      it.disp_y = $urandom;
      it.disp_z = $urandom;
      it.last_bond = 1'($urandom_range(1));
      if (slot < SLOTS) begin
         written[ty][slot] = 1'b1;
         if (written[ty] == 15'h7FFF) begin
            ready_types.push_back(ty);
            written[ty] = 15'h7FFE; // keep it from being pushed twice
         end
      end
      return it;
   endfunction

   function automatic req_item_type bond(int ty, logic [31:0] dx, logic [31:0] dy,
                                         logic [31:0] dz, bit last);
      req_item_type it;
      it = '0;
      it.op = OP_EVAL;
      it.bond_type = 6'(ty);
      it.coef_slot = 4'($urandom);
      it.coef_value = $urandom;
      it.disp_x = dx;
      it.disp_y = dy;
      it.disp_z = dz;
      it.last_bond = last;
      return it;
   endfunction

   function automatic req_item_type rand_item();
      if ($urandom_range(99) < 15)
         return coef_write($urandom_range(NUM_TYPES - 1), $urandom_range(15), rand_word());
      return bond(ready_types[$urandom_range(ready_types.size() - 1)], rand_word(),
                  rand_word(), rand_word(), $urandom_range(7) == 0);
   endfunction

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      pop_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         // stretches with no idling inside every phase
         if (i % 100 == 50) begin
            send_idle_pct = 0;
            pop_stall_pct = 0;
         end else if (i % 100 == 80) begin
            send_idle_pct = idle;
            pop_stall_pct = stall;
         end
         send(rand_item());
      end
      settle();
   endtask

   initial begin
      req_push      <= 1'b0;
      req_item      <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_FORCE_WEIGHT;
      csr_wdata     <= '0;
      rsp_pop       <= 1'b0;
      hold_off      = 0;
      cycles        = 0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      foreach (written[i]) written[i] = '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Table setup for the lowest and highest type, slot 15 ignored
      for (int s = 0; s < SLOTS; s++) begin
         send(coef_write(0, s, (s == SLOT_EQ || s == SLOT_EQR) ? 32'h0001_0000 :
                                 32'h0000_4000 * (s + 1)));
         send(coef_write(NUM_TYPES - 1, s, (s % 2) ? 32'h7FFF_FFFF : 32'h8000_0000));
      end
      send(coef_write(0, 15, 32'hDEAD_BEEF));

      // Directed bonds: zero length, extremes, batch ends
      send(bond(0, 0, 0, 0, 1'b0));
      send(bond(0, 32'h0001_0000, 0, 0, 1'b0));
      send(bond(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      send(bond(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send(bond(NUM_TYPES - 1, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000, 1'b0));
      send(bond(NUM_TYPES - 1, 0, 0, 0, 1'b1));
      send(bond(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1));
      settle();
      write_reg(CSR_PRESSURE_MODE, 2);
      write_reg(CSR_EQ_SELECT, 1);
      write_reg(CSR_FORCE_WEIGHT, 32'h8000_0000);
      send(bond(0, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 1'b0));
      send(bond(NUM_TYPES - 1, 32'h0001_0000, 0, 0, 1'b0));
      send(bond(0, 32'h0003_0000, 32'h0004_0000, 0, 1'b1));
      settle();

      // Phase one: no idling, long response hold-off to back up the queue
      write_reg(CSR_FORCE_WEIGHT, 32'h0001_0000);
      write_reg(CSR_PRESSURE_MODE, 1);
      write_reg(CSR_EQ_SELECT, 0);
      hold_off = 1500;
      run_phase(330, 0, 0);

      write_reg(CSR_FORCE_WEIGHT, 32'h7FFF_FFFF);
      write_reg(CSR_PRESSURE_MODE, 3);
      write_reg(CSR_EQ_SELECT, 1);
      run_phase(330, 73, 0);

      write_reg(CSR_FORCE_WEIGHT, 32'h0000_0000);
      write_reg(CSR_PRESSURE_MODE, 0);
      write_reg(CSR_EQ_SELECT, 0);
      run_phase(330, 0, 73);

      write_reg(CSR_FORCE_WEIGHT, $urandom);
      write_reg(CSR_PRESSURE_MODE, 2);
      write_reg(CSR_EQ_SELECT, 1);
      run_phase(330, 16, 16);

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
